@@ design/sovme_pkg.sv @@
// Package for the strided move engine: memory size, field widths, codes and
// the types shared by the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package sovme_pkg;

  // Memory geometry.
  localparam int MEM_DEPTH = 1024;
  localparam int WORD_BITS = 32;
  localparam int AW        = $clog2(MEM_DEPTH);

  // Fixed field widths of a command word.
  localparam int ACT_W    = 3;
  localparam int ADDR_W   = 10;
  localparam int CNT_W    = 11;
  localparam int STRIDE_W = 10;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;

  // Wide address arithmetic: start + (count - 1) * stride plus one more stride.
  localparam int XW = CNT_W + STRIDE_W + 1;

  // Command codes.
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MOVE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COPY  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FILL  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_STRIDE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE      = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [ADDR_W-1:0]   dst_addr;
    logic [ADDR_W-1:0]   src_addr;
    logic [CNT_W-1:0]    count;
    logic [STRIDE_W-1:0] dst_stride;
    logic [STRIDE_W-1:0] src_stride;
    logic [DATA_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [STAT_W-1:0] status;
  } rsp_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_SPAN,
    DP_WRITE,
    DP_READ,
    DP_CAPTURE,
    DP_DIV,
    DP_PLAN,
    DP_INIT_UP,
    DP_INIT_DN,
    DP_STEP_UP,
    DP_STEP_DN,
    DP_RESULT
  } dp_op_e;

  // Transfer order class of a move.
  typedef enum logic [1:0] {
    CLS_UP,
    CLS_DN,
    CLS_SPLIT
  } cls_e;

  typedef struct packed {
    dp_op_e            op;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic [ACT_W-1:0] action;
    logic             n_zero;
    logic             a_zero;
    logic             b_zero;
    logic             d_oor;
    logic             span_d_bad;
    logic             span_s_bad;
    cls_e             cls;
    logic             div_done;
    logic             cnt_zero;
  } dp_flags_t;

endpackage

`default_nettype wire

@@ design/strided_overlap_safe_move_engine.sv @@
// Top level of the strided move engine: joins the controller and the
// datapath. Depends on sovme_pkg, sovme_ctrl and sovme_dp.
//
//   Channel   Handshake                  Word
//   in        in_valid_i / in_ready_o    in_req_i   (req_t)
//   out       out_valid_o / out_ready_i  out_rsp_o  (rsp_t)
//
// After reset the word memory is cleared one word a cycle, all MEM_DEPTH words,
// before the first command is taken.
// A move whose element sets interleave also runs the crossover division.
// One memory write port sets the transfer rate.
// A finished word waits in the output register while the next command runs.
`default_nettype none

module strided_overlap_safe_move_engine
  import sovme_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // Sequencer.
  sovme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // Arithmetic, memory and result register.
  sovme_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (in_req_i),
    .cmd_i   (cmd),
    .flags_o (flags),
    .rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

@@ design/sovme_ram.sv @@
// Generic single-clock RAM: one write port and one read port with a
// registered read. Depends on nothing.
`default_nettype none

module sovme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/sovme_div.sv @@
// Radix-2 restoring divider that finds the crossover index of a move,
// one quotient bit per cycle. Depends on sovme_pkg.
`default_nettype none

module sovme_div
  import sovme_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] num_i,
  input  wire logic [ADDR_W-1:0] den_i,
  output logic                   done_o,
  output logic      [ADDR_W-1:0] quo_o
);

  localparam int CW = $clog2(ADDR_W + 1);

  logic [ADDR_W:0]   rem_q;
  logic [ADDR_W-1:0] quo_q;
  logic [ADDR_W-1:0] den_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [ADDR_W:0]   shifted;
  logic [ADDR_W+1:0] diff;

  // Trial subtraction for the next quotient bit.
  always_comb begin
    shifted = {rem_q[ADDR_W-1:0], quo_q[ADDR_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ADDR_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[ADDR_W+1]) begin
        rem_q <= diff[ADDR_W:0];
        quo_q <= {quo_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[ADDR_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ design/sovme_dp.sv @@
// Datapath of the strided move engine: command registers, span and overlap
// arithmetic, address walkers, the word memory and the crossover divider.
// Depends on sovme_pkg, sovme_ram and sovme_div.
`default_nettype none

module sovme_dp
  import sovme_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire req_t      req_i,
  input  wire dp_cmd_t   cmd_i,
  output dp_flags_t      flags_o,
  output rsp_t           rsp_o
);

  localparam int PW = CNT_W + STRIDE_W;

  req_t              req_q;
  logic [XW-1:0]     lastd_q, lasts_q, endd_q, ends_q;
  logic [CNT_W-1:0]  su_q, nu_q, sd_q, cnt_q;
  logic [XW-1:0]     wd_q, ws_q;
  logic              wr_pend_q, fwd_q;
  logic [AW-1:0]     wr_addr_q, clr_q;
  logic [WORD_BITS-1:0] last_wdata_q;
  logic [DATA_W-1:0] rd_q;
  rsp_t              rsp_q;

  logic [XW-1:0]     d_x, s_x, a_x, b_x, depth_x;
  logic [CNT_W-1:0]  k_sel;
  logic [PW-1:0]     prod_a, prod_b;
  logic              a_gt_b, disjoint;
  cls_e              cls;
  logic [ADDR_W-1:0] div_num, div_den, quo;
  logic              div_done;
  logic [CNT_W-1:0]  qc;
  logic              fill_mode, step;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, rdata, pipe_wdata;

  assign d_x     = XW'(req_q.dst_addr);
  assign s_x     = XW'(req_q.src_addr);
  assign a_x     = XW'(req_q.dst_stride);
  assign b_x     = XW'(req_q.src_stride);
  assign depth_x = XW'(MEM_DEPTH);
  assign a_gt_b  = req_q.dst_stride > req_q.src_stride;
  assign fill_mode = req_q.action == ACT_FILL;
  assign step    = cmd_i.op == DP_STEP_UP || cmd_i.op == DP_STEP_DN;

  // Shared multiplier pair: element index times each stride.
  always_comb begin
    unique case (cmd_i.op)
      DP_INIT_UP: k_sel = su_q;
      DP_INIT_DN: k_sel = sd_q - 1'b1;
      default:    k_sel = req_q.count - 1'b1;
    endcase
    prod_a = k_sel * req_q.dst_stride;
    prod_b = k_sel * req_q.src_stride;
  end

  // Order class of a move from the end points of both element sets.
  always_comb begin
    disjoint = endd_q <= s_x || d_x >= ends_q;
    if (disjoint) begin
      cls = CLS_UP;
    end else if (req_q.dst_stride == req_q.src_stride) begin
      cls = (d_x <= s_x) ? CLS_UP : CLS_DN;
    end else if (a_gt_b) begin
      if (d_x >= s_x) cls = CLS_DN;
      else if (endd_q <= ends_q) cls = CLS_UP;
      else cls = CLS_SPLIT;
    end else begin
      if (s_x >= d_x) cls = CLS_UP;
      else if (ends_q <= endd_q) cls = CLS_DN;
      else cls = CLS_SPLIT;
    end
  end

  // Crossover divider operands.
  always_comb begin
    if (a_gt_b) begin
      div_num = req_q.src_addr - req_q.dst_addr;
      div_den = req_q.dst_stride - req_q.src_stride;
    end else begin
      div_num = req_q.dst_addr - req_q.src_addr;
      div_den = req_q.src_stride - req_q.dst_stride;
    end
  end

  sovme_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == DP_DIV),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign qc = (CNT_W'(quo) > req_q.count) ? req_q.count : CNT_W'(quo);

  // Memory port selection.
  always_comb begin
    pipe_wdata = fill_mode ? WORD_BITS'(req_q.value) : (fwd_q ? last_wdata_q : rdata);
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = pipe_wdata;
    if (cmd_i.op == DP_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.op == DP_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = req_q.dst_addr[AW-1:0];
      mem_wdata = WORD_BITS'(req_q.value);
    end else if (wr_pend_q) begin
      mem_we = 1'b1;
    end
    mem_re    = cmd_i.op == DP_READ || (step && !fill_mode);
    mem_raddr = (cmd_i.op == DP_READ) ? req_q.dst_addr[AW-1:0] : ws_q[AW-1:0];
  end

  sovme_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Control registers: clearing sweep and the write stage of the transfer pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_CLEAR) clr_q <= clr_q + 1'b1;
      wr_pend_q <= step;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) last_wdata_q <= pipe_wdata;
    // A read of the word written in the same cycle takes the written data.
    fwd_q <= step && wr_pend_q && ws_q[AW-1:0] == wr_addr_q;
    if (step) begin
      wr_addr_q <= wd_q[AW-1:0];
      cnt_q     <= cnt_q - 1'b1;
    end
    unique case (cmd_i.op)
      DP_LOAD: begin
        req_q <= req_i;
        rd_q  <= '0;
      end
      DP_SPAN: begin
        lastd_q <= d_x + XW'(prod_a);
        lasts_q <= s_x + XW'(prod_b);
        endd_q  <= d_x + XW'(prod_a) + a_x;
        ends_q  <= s_x + XW'(prod_b) + b_x;
      end
      DP_CAPTURE: rd_q <= DATA_W'(rdata);
      DP_PLAN: begin
        if (req_q.action != ACT_MOVE || cls == CLS_UP) begin
          su_q <= '0;
          nu_q <= req_q.count;
          sd_q <= req_q.count;
        end else if (cls == CLS_DN) begin
          su_q <= '0;
          nu_q <= '0;
          sd_q <= req_q.count;
        end else if (a_gt_b) begin
          su_q <= '0;
          nu_q <= qc;
          sd_q <= req_q.count;
        end else begin
          su_q <= qc;
          nu_q <= req_q.count - qc;
          sd_q <= qc;
        end
      end
      DP_INIT_UP: begin
        wd_q  <= d_x + XW'(prod_a);
        ws_q  <= s_x + XW'(prod_b);
        cnt_q <= nu_q;
      end
      DP_INIT_DN: begin
        wd_q  <= d_x + XW'(prod_a);
        ws_q  <= s_x + XW'(prod_b);
        cnt_q <= req_q.count - nu_q;
      end
      DP_STEP_UP: begin
        wd_q <= wd_q + a_x;
        ws_q <= ws_q + b_x;
      end
      DP_STEP_DN: begin
        wd_q <= wd_q - a_x;
        ws_q <= ws_q - b_x;
      end
      DP_RESULT: rsp_q <= '{read_data: rd_q, status: cmd_i.status};
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    flags_o.clr_done   = clr_q == AW'(MEM_DEPTH - 1);
    flags_o.action     = req_q.action;
    flags_o.n_zero     = req_q.count == '0;
    flags_o.a_zero     = req_q.dst_stride == '0;
    flags_o.b_zero     = req_q.src_stride == '0;
    flags_o.d_oor      = d_x >= depth_x;
    flags_o.span_d_bad = lastd_q >= depth_x;
    flags_o.span_s_bad = lasts_q >= depth_x;
    flags_o.cls        = cls;
    flags_o.div_done   = div_done;
    flags_o.cnt_zero   = cnt_q == '0;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

@@ design/sovme_ctrl.sv @@
// Controller of the strided move engine: sequences the clearing sweep, the
// checks, the crossover division and the transfer phases, and owns the
// handshakes. Depends on sovme_pkg.
`default_nettype none

module sovme_ctrl
  import sovme_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dp_flags_t flags_i,
  output dp_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SPAN,
    S_DECIDE,
    S_READ,
    S_CAPTURE,
    S_DIV,
    S_DIV_WAIT,
    S_PLAN,
    S_INIT_UP,
    S_RUN_UP,
    S_INIT_DN,
    S_RUN_DN,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              out_valid_q;
  logic              slot_free;
  dp_op_e            op;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state, status and datapath operation.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    op       = DP_NOP;
    unique case (state_q)
      S_CLEAR: begin
        op = DP_CLEAR;
        if (flags_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op      = DP_LOAD;
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        op      = DP_SPAN;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        status_d = STAT_OK;
        state_d  = S_DONE;
        priority case (flags_i.action)
          ACT_WRITE: begin
            if (flags_i.d_oor) status_d = STAT_RANGE;
            else op = DP_WRITE;
          end
          ACT_READ: begin
            if (flags_i.d_oor) status_d = STAT_RANGE;
            else state_d = S_READ;
          end
          ACT_MOVE, ACT_COPY: begin
            if (flags_i.n_zero) begin
              status_d = STAT_OK;
            end else if (flags_i.a_zero || flags_i.b_zero) begin
              status_d = STAT_BAD_STRIDE;
            end else if (flags_i.span_d_bad || flags_i.span_s_bad) begin
              status_d = STAT_RANGE;
            end else if (flags_i.action == ACT_MOVE && flags_i.cls == CLS_SPLIT) begin
              state_d = S_DIV;
            end else begin
              state_d = S_PLAN;
            end
          end
          ACT_FILL: begin
            if (flags_i.a_zero) status_d = STAT_BAD_STRIDE;
            else if (flags_i.n_zero) status_d = STAT_OK;
            else if (flags_i.span_d_bad) status_d = STAT_RANGE;
            else state_d = S_PLAN;
          end
          default: ;
        endcase
      end
      S_READ: begin
        op      = DP_READ;
        state_d = S_CAPTURE;
      end
      S_CAPTURE: begin
        op      = DP_CAPTURE;
        state_d = S_DONE;
      end
      S_DIV: begin
        op      = DP_DIV;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (flags_i.div_done) state_d = S_PLAN;
      end
      S_PLAN: begin
        op      = DP_PLAN;
        state_d = S_INIT_UP;
      end
      S_INIT_UP: begin
        op      = DP_INIT_UP;
        state_d = S_RUN_UP;
      end
      S_RUN_UP: begin
        if (flags_i.cnt_zero) state_d = S_INIT_DN;
        else op = DP_STEP_UP;
      end
      S_INIT_DN: begin
        op      = DP_INIT_DN;
        state_d = S_RUN_DN;
      end
      S_RUN_DN: begin
        if (flags_i.cnt_zero) state_d = S_DONE;
        else op = DP_STEP_DN;
      end
      S_DONE: begin
        if (slot_free) begin
          op      = DP_RESULT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = '{op: op, status: status_q};

endmodule

`default_nettype wire
